@@ rtl/core/gasp_pkg.sv @@
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared types, sizes and helpers of the grid A* path search block.
// ----------------------------------------------------------------------------
package gasp_pkg;

  // Grid geometry. The coordinate fields are 6 bits, so the grid is 64 x 64
  // and every coordinate that arrives lies inside it.
  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int CELLS   = GRID_W * GRID_H;
  localparam int COORD_W = $clog2(GRID_W);
  localparam int CELL_W  = $clog2(CELLS);       // cell number y*GRID_W+x
  localparam int IDX_W   = $clog2(CELLS + 1);   // heap slots, path nodes, lengths
  localparam int ID_W    = CELL_W;              // open-list item number
  localparam int COST_W  = 17;
  localparam int H_W     = 11;

  localparam logic [COST_W-1:0] COST_MAX      = '1;
  localparam logic [COST_W-1:0] STEP_STRAIGHT = COST_W'(10);
  localparam logic [COST_W-1:0] STEP_DIAGONAL = COST_W'(14);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_FOUND   = 3'd1,
    STAT_SAME    = 3'd2,
    STAT_BLOCKED = 3'd3,
    STAT_NO_PATH = 3'd4,
    STAT_RANGE   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_OPEN   = 2'd1,
    MARK_CLOSED = 2'd2
  } mark_e;

  // Saturating cost add.
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

@@ rtl/core/gasp_ram.sv @@
// ----------------------------------------------------------------------------
// gasp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gasp_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/grid_astar_path_search_top.sv @@
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search on a 64 x 64 grid with 8-way moves and a binary min-heap open
// list, run by a sequencer over memories with one write and one read port.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                  | Contents
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | command, cell, target, node index
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | status, path length, node
//
// A search first clears the list marks, then for each expanded cell pops it
// and steps over its nine neighbor positions, with more work for each
// neighbor that passes the bounds check, for each heap level sunk or risen
// and for each heap slot scanned when a cost improves; the heap memory's
// single read port sets this pace.
// After reset every map cell is swept to walkable; no request is taken
// meanwhile. One request is worked on at a time; a result waits in the
// output register, and a new request is taken while it waits.
module grid_astar_path_search_top
  import gasp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] cell_x, [11:6] cell_y, [12] walkable, [18:13] target_x,
  // [24:19] target_y, [37:25] node_index, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [12:0] path_length, [18:13] node_x, [24:19] node_y, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);

  typedef enum logic [5:0] {
    S_FILL, S_IDLE, S_DECODE, S_RDATA, S_TCHK, S_CLEAR, S_INIT,
    S_POP0, S_POP1, S_POP2, S_POP3,
    S_SINKF, S_SINK0, S_SINK1, S_SINK2, S_SINK3, S_SINKW,
    S_EXP0, S_EXP1, S_EXP2, S_EXP3, S_EXPG, S_NEW0, S_IMPR0,
    S_SCAN0, S_SCAN1, S_SCAN2,
    S_RISE0, S_RISE1, S_RISE2, S_RISEW, S_NEXT,
    S_PL0, S_PL1, S_PW0, S_PW1, S_FINISH
  } state_e;

  state_e state_q;

  // Captured request.
  cmd_e               cmd_q;
  logic [COORD_W-1:0] cx_q, cy_q, tx_q, ty_q;
  logic               wk_q;
  logic [IDX_W-1:0]   idx_q;

  // Search state.
  logic [IDX_W-1:0]   found_len_q, count_q, u_q, k_q, len_q, clr_q;
  logic [ID_W-1:0]    next_id_q, hid_q, id_l_q, id_r_q;
  logic [CELL_W-1:0]  p_q, c_q;
  logic [COORD_W-1:0] a_q, b_q;
  logic [COST_W-1:0]  gp_q, ng_q, fm_q, f_l_q;
  logic [1:0]         dx_q, dy_q;
  mark_e              mark_c_q;
  logic               strict_q, tgt_open_q;

  // Result and output register.
  status_e            res_status_q;
  logic [COORD_W-1:0] res_nx_q, res_ny_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [IDX_W-1:0]   out_len_q;
  logic [COORD_W-1:0] out_nx_q, out_ny_q;

  // Memory ports.
  logic                walk_we, walk_wd, walk_rd;
  logic [CELL_W-1:0]   walk_wa, walk_ra;
  logic                mark_we;
  logic [1:0]          mark_wd, mark_rd;
  logic [CELL_W-1:0]   mark_wa, mark_ra;
  logic                par_we;
  logic [CELL_W-1:0]   par_wa, par_ra, par_wd, par_rd;
  logic                g_we;
  logic [CELL_W-1:0]   g_wa, g_ra;
  logic [COST_W-1:0]   g_wd, g_rd;
  logic                heap_we;
  logic [IDX_W-1:0]    heap_wa, heap_ra;
  logic [ID_W-1:0]     heap_wd, heap_rd;
  logic                ocell_we;
  logic [ID_W-1:0]     ocell_wa, ocell_ra;
  logic [CELL_W-1:0]   ocell_wd, ocell_rd;
  logic                of_we;
  logic [ID_W-1:0]     of_wa, of_ra;
  logic [COST_W-1:0]   of_wd, of_rd;
  logic                oh_we;
  logic [ID_W-1:0]     oh_wa, oh_ra;
  logic [H_W-1:0]      oh_wd, oh_rd;
  logic                path_we;
  logic [IDX_W-1:0]    path_wa, path_ra;
  logic [CELL_W-1:0]   path_wd, path_rd;

  // Derived values.
  logic [CELL_W-1:0]  s_cell, t_cell;
  logic [COORD_W-1:0] px, py, na, nb, adx, ady;
  logic               nb_ok, center, diag;
  logic [COORD_W:0]   hsum;
  logic [H_W-1:0]     h_new;
  logic [COST_W-1:0]  f_new, f_imp;
  logic [IDX_W:0]     u2, u2p1;
  logic               has_l, has_r;
  logic [ID_W-1:0]    nid;
  logic               fire_in, out_free;

  assign s_cell  = {cy_q, cx_q};
  assign t_cell  = {ty_q, tx_q};
  assign px      = p_q[COORD_W-1:0];
  assign py      = p_q[CELL_W-1:COORD_W];
  assign fire_in = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Neighbor coordinates; dx_q and dy_q count 0..2 for offsets -1..+1.
  assign na     = px + COORD_W'(dx_q) - COORD_W'(1);
  assign nb     = py + COORD_W'(dy_q) - COORD_W'(1);
  assign nb_ok  = !((dx_q == 2'd0) && (px == '0)) && !((dx_q == 2'd2) && (px == '1)) &&
                  !((dy_q == 2'd0) && (py == '0)) && !((dy_q == 2'd2) && (py == '1));
  assign center = (dx_q == 2'd1) && (dy_q == 2'd1);
  assign diag   = (dx_q != 2'd1) && (dy_q != 2'd1);

  // Heuristic: ten times the Manhattan distance, at most 1260 on this grid.
  assign adx   = (a_q >= tx_q) ? a_q - tx_q : tx_q - a_q;
  assign ady   = (b_q >= ty_q) ? b_q - ty_q : ty_q - b_q;
  assign hsum  = {1'b0, adx} + {1'b0, ady};
  assign h_new = H_W'({hsum, 3'b000}) + H_W'({hsum, 1'b0});
  assign f_new = sat_add(ng_q, COST_W'(h_new));
  assign f_imp = sat_add(ng_q, COST_W'(oh_rd));
  assign nid   = next_id_q + ID_W'(1);

  // Heap child positions.
  assign u2    = {u_q, 1'b0};
  assign u2p1  = {u_q, 1'b1};
  assign has_l = u2 <= {1'b0, count_q};
  assign has_r = u2p1 <= {1'b0, count_q};

  assign s_axis_tready = (state_q == S_IDLE);

  // Memory address, write and read selection per sequencer state.
  always_comb begin
    walk_we = 1'b0; walk_wa = '0; walk_wd = 1'b0; walk_ra = '0;
    mark_we = 1'b0; mark_wa = '0; mark_wd = MARK_NONE; mark_ra = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
    ocell_we = 1'b0; ocell_wa = '0; ocell_wd = '0; ocell_ra = '0;
    of_we = 1'b0; of_wa = '0; of_wd = '0; of_ra = '0;
    oh_we = 1'b0; oh_wa = '0; oh_wd = '0; oh_ra = '0;
    path_we = 1'b0; path_wa = '0; path_wd = '0; path_ra = '0;
    unique case (state_q)
      S_FILL: begin
        walk_we = 1'b1; walk_wa = clr_q[CELL_W-1:0]; walk_wd = 1'b1;
      end
      S_DECODE: begin
        if (cmd_q == CMD_LOAD) begin
          walk_we = 1'b1; walk_wa = s_cell; walk_wd = wk_q;
        end
        walk_ra = t_cell;
        path_ra = idx_q;
      end
      S_CLEAR: begin
        mark_we = 1'b1; mark_wa = clr_q[CELL_W-1:0]; mark_wd = MARK_NONE;
      end
      S_INIT: begin
        g_we = 1'b1; g_wa = s_cell; g_wd = '0;
        heap_we = 1'b1; heap_wa = IDX_W'(1); heap_wd = ID_W'(1);
        ocell_we = 1'b1; ocell_wa = ID_W'(1); ocell_wd = s_cell;
      end
      S_POP0: heap_ra = IDX_W'(1);
      S_POP1: ocell_ra = heap_rd;
      S_POP2: begin
        mark_we = 1'b1; mark_wa = ocell_rd; mark_wd = MARK_CLOSED;
        g_ra = ocell_rd;
        heap_ra = count_q;
      end
      S_POP3: begin
        heap_we = 1'b1; heap_wa = IDX_W'(1); heap_wd = heap_rd;
        of_ra = heap_rd;
      end
      S_SINK0: heap_ra = u2[IDX_W-1:0];
      S_SINK1: begin
        of_ra = heap_rd;
        heap_ra = u2p1[IDX_W-1:0];
      end
      S_SINK2: of_ra = heap_rd;
      S_SINK3, S_RISE2: begin
        heap_wa = u_q;
        heap_wd = (state_q == S_SINK3 && has_r && ((fm_q >= f_l_q) ? f_l_q : fm_q) >= of_rd)
                  ? id_r_q : id_l_q;
        heap_we = 1'b0;
        if (state_q == S_SINK3) begin
          heap_we = (fm_q >= f_l_q) || (has_r && fm_q >= of_rd);
        end else begin
          heap_we = strict_q ? (fm_q < of_rd) : (fm_q <= of_rd);
        end
      end
      S_SINKW, S_RISEW: begin
        heap_we = 1'b1; heap_wa = u_q; heap_wd = hid_q;
      end
      S_EXP0: begin
        walk_ra = {nb, na};
        mark_ra = {nb, na};
      end
      S_EXP1: walk_ra = {py, a_q};
      S_EXP2: walk_ra = {b_q, px};
      S_EXPG: g_ra = c_q;
      S_NEW0: begin
        ocell_we = 1'b1; ocell_wa = nid; ocell_wd = c_q;
        g_we = 1'b1; g_wa = c_q; g_wd = ng_q;
        oh_we = 1'b1; oh_wa = nid; oh_wd = h_new;
        of_we = 1'b1; of_wa = nid; of_wd = f_new;
        par_we = 1'b1; par_wa = c_q; par_wd = p_q;
        mark_we = 1'b1; mark_wa = c_q; mark_wd = MARK_OPEN;
      end
      S_IMPR0: begin
        if (ng_q < g_rd) begin
          par_we = 1'b1; par_wa = c_q; par_wd = p_q;
          g_we = 1'b1; g_wa = c_q; g_wd = ng_q;
        end
      end
      S_SCAN0: heap_ra = k_q;
      S_SCAN1: begin
        ocell_ra = heap_rd;
        oh_ra = heap_rd;
      end
      S_SCAN2: begin
        if (ocell_rd == c_q) begin
          of_we = 1'b1; of_wa = hid_q; of_wd = f_imp;
        end
      end
      S_RISE0: heap_ra = u_q >> 1;
      S_RISE1: of_ra = heap_rd;
      S_PL0: par_ra = c_q;
      S_PW0: begin
        path_we = 1'b1;
        if (k_q == '0) begin
          path_wa = '0; path_wd = s_cell;
        end else begin
          path_wa = k_q; path_wd = c_q;
        end
        par_ra = c_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_FILL;
      clr_q        <= '0;
      found_len_q  <= '0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      next_id_q    <= '0;
      tgt_open_q   <= 1'b0;
      strict_q     <= 1'b0;
      cmd_q        <= CMD_UNUSED;
      res_status_q <= STAT_DONE;
      out_status_q <= STAT_DONE;
      mark_c_q     <= MARK_NONE;
      dx_q         <= '0;
      dy_q         <= '0;
    end else begin
      // The finishing state reloads the output register itself.
      if (out_valid_q && m_axis_tready && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        // Sweep the map to walkable after reset.
        S_FILL: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (fire_in) begin
            cmd_q   <= cmd_e'(s_axis_tuser);
            cx_q    <= s_axis_tdata[5:0];
            cy_q    <= s_axis_tdata[11:6];
            wk_q    <= s_axis_tdata[12];
            tx_q    <= s_axis_tdata[18:13];
            ty_q    <= s_axis_tdata[24:19];
            idx_q   <= s_axis_tdata[37:25];
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_nx_q <= '0;
          res_ny_q <= '0;
          unique case (cmd_q)
            CMD_LOAD, CMD_UNUSED: begin
              res_status_q <= STAT_DONE;
              state_q      <= S_FINISH;
            end
            CMD_SEARCH: begin
              if (s_cell == t_cell) begin
                res_status_q <= STAT_SAME;
                state_q      <= S_FINISH;
              end else begin
                state_q <= S_TCHK;
              end
            end
            CMD_READ: begin
              if (found_len_q == '0 || idx_q > found_len_q) begin
                res_status_q <= STAT_RANGE;
                state_q      <= S_FINISH;
              end else begin
                state_q <= S_RDATA;
              end
            end
          endcase
        end
        S_RDATA: begin
          res_status_q <= STAT_DONE;
          res_nx_q     <= path_rd[COORD_W-1:0];
          res_ny_q     <= path_rd[CELL_W-1:COORD_W];
          state_q      <= S_FINISH;
        end
        // The target must be walkable; then clear the list marks.
        S_TCHK: begin
          if (!walk_rd) begin
            res_status_q <= STAT_BLOCKED;
            state_q      <= S_FINISH;
          end else begin
            found_len_q <= '0;
            clr_q       <= '0;
            state_q     <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(CELLS - 1)) begin
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          count_q    <= IDX_W'(1);
          next_id_q  <= '0;
          tgt_open_q <= 1'b0;
          state_q    <= S_POP0;
        end
        // Take the top of the heap and close its cell.
        S_POP0: begin
          if (count_q == '0) begin
            res_status_q <= STAT_NO_PATH;
            state_q      <= S_FINISH;
          end else begin
            state_q <= S_POP1;
          end
        end
        S_POP1: state_q <= S_POP2;
        S_POP2: begin
          p_q     <= ocell_rd;
          count_q <= count_q - IDX_W'(1);
          state_q <= S_POP3;
        end
        S_POP3: begin
          gp_q    <= g_rd;
          hid_q   <= heap_rd;
          state_q <= S_SINKF;
        end
        // Sink the moved item, keeping a hole until its place is found.
        S_SINKF: begin
          fm_q    <= of_rd;
          u_q     <= IDX_W'(1);
          state_q <= S_SINK0;
        end
        S_SINK0: state_q <= has_l ? S_SINK1 : S_SINKW;
        S_SINK1: begin
          id_l_q  <= heap_rd;
          state_q <= S_SINK2;
        end
        S_SINK2: begin
          f_l_q   <= of_rd;
          id_r_q  <= heap_rd;
          state_q <= S_SINK3;
        end
        S_SINK3: begin
          if (has_r && ((fm_q >= f_l_q) ? f_l_q : fm_q) >= of_rd) begin
            u_q     <= u2p1[IDX_W-1:0];
            state_q <= S_SINK0;
          end else if (fm_q >= f_l_q) begin
            u_q     <= u2[IDX_W-1:0];
            state_q <= S_SINK0;
          end else begin
            state_q <= S_SINKW;
          end
        end
        S_SINKW: begin
          dx_q    <= '0;
          dy_q    <= '0;
          state_q <= S_EXP0;
        end
        // Visit the eight neighbors of the closed cell.
        S_EXP0: begin
          a_q <= na;
          b_q <= nb;
          c_q <= {nb, na};
          state_q <= (!nb_ok || center) ? S_NEXT : S_EXP1;
        end
        S_EXP1: begin
          mark_c_q <= mark_e'(mark_rd);
          if (mark_rd == MARK_CLOSED || !walk_rd) begin
            state_q <= S_NEXT;
          end else if (diag) begin
            state_q <= S_EXP2;
          end else begin
            ng_q    <= sat_add(gp_q, STEP_STRAIGHT);
            state_q <= S_EXPG;
          end
        end
        // Diagonal moves need both orthogonal cells walkable.
        S_EXP2: state_q <= walk_rd ? S_EXP3 : S_NEXT;
        S_EXP3: begin
          if (walk_rd) begin
            ng_q    <= sat_add(gp_q, STEP_DIAGONAL);
            state_q <= S_EXPG;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_EXPG: state_q <= (mark_c_q == MARK_OPEN) ? S_IMPR0 : S_NEW0;
        S_NEW0: begin
          next_id_q <= nid;
          hid_q     <= nid;
          fm_q      <= f_new;
          u_q       <= count_q + IDX_W'(1);
          count_q   <= count_q + IDX_W'(1);
          strict_q  <= 1'b0;
          if (c_q == t_cell) begin
            tgt_open_q <= 1'b1;
          end
          state_q <= S_RISE0;
        end
        S_IMPR0: begin
          k_q     <= IDX_W'(1);
          state_q <= (ng_q < g_rd) ? S_SCAN0 : S_NEXT;
        end
        // Find the heap slot of the improved cell.
        S_SCAN0: state_q <= (k_q > count_q) ? S_NEXT : S_SCAN1;
        S_SCAN1: begin
          hid_q   <= heap_rd;
          state_q <= S_SCAN2;
        end
        S_SCAN2: begin
          if (ocell_rd == c_q) begin
            fm_q     <= f_imp;
            u_q      <= k_q;
            strict_q <= 1'b1;
            state_q  <= S_RISE0;
          end else begin
            k_q     <= k_q + IDX_W'(1);
            state_q <= S_SCAN0;
          end
        end
        // Raise an item toward the root, keeping a hole.
        S_RISE0: state_q <= (u_q == IDX_W'(1)) ? S_RISEW : S_RISE1;
        S_RISE1: begin
          id_l_q  <= heap_rd;
          state_q <= S_RISE2;
        end
        S_RISE2: begin
          if (strict_q ? (fm_q < of_rd) : (fm_q <= of_rd)) begin
            u_q     <= u_q >> 1;
            state_q <= S_RISE0;
          end else begin
            state_q <= S_RISEW;
          end
        end
        S_RISEW: state_q <= S_NEXT;
        S_NEXT: begin
          if (dx_q == 2'd2 && dy_q == 2'd2) begin
            c_q     <= t_cell;
            len_q   <= '0;
            state_q <= tgt_open_q ? S_PL0 : S_POP0;
          end else begin
            if (dx_q == 2'd2) begin
              dx_q <= '0;
              dy_q <= dy_q + 2'd1;
            end else begin
              dx_q <= dx_q + 2'd1;
            end
            state_q <= S_EXP0;
          end
        end
        // Count the path length by walking parents back to the start.
        S_PL0: begin
          if (c_q == s_cell || len_q == IDX_W'(CELLS)) begin
            k_q     <= len_q;
            c_q     <= t_cell;
            state_q <= S_PW0;
          end else begin
            state_q <= S_PL1;
          end
        end
        S_PL1: begin
          c_q     <= par_rd;
          len_q   <= len_q + IDX_W'(1);
          state_q <= S_PL0;
        end
        // Store the path from the target end down to the start.
        S_PW0: begin
          if (k_q == '0) begin
            found_len_q  <= len_q;
            res_status_q <= STAT_FOUND;
            state_q      <= S_FINISH;
          end else begin
            state_q <= S_PW1;
          end
        end
        S_PW1: begin
          c_q     <= par_rd;
          k_q     <= k_q - IDX_W'(1);
          state_q <= S_PW0;
        end
        // Hand the result to the output register.
        S_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_len_q    <= found_len_q;
            out_nx_q     <= res_nx_q;
            out_ny_q     <= res_ny_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_ny_q, out_nx_q, out_len_q};

  // Memories.
  gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_walk (
    .clk_i, .we_i(walk_we), .waddr_i(walk_wa), .wdata_i(walk_wd),
    .raddr_i(walk_ra), .rdata_o(walk_rd));
  gasp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(mark_ra), .rdata_o(mark_rd));
  gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent (
    .clk_i, .we_i(par_we), .waddr_i(par_wa), .wdata_i(par_wd),
    .raddr_i(par_ra), .rdata_o(par_rd));
  gasp_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_gcost (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd),
    .raddr_i(g_ra), .rdata_o(g_rd));
  gasp_ram #(.WIDTH(ID_W), .DEPTH(CELLS + 1)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .raddr_i(heap_ra), .rdata_o(heap_rd));
  gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ocell (
    .clk_i, .we_i(ocell_we), .waddr_i(ocell_wa), .wdata_i(ocell_wd),
    .raddr_i(ocell_ra), .rdata_o(ocell_rd));
  gasp_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_of (
    .clk_i, .we_i(of_we), .waddr_i(of_wa), .wdata_i(of_wd),
    .raddr_i(of_ra), .rdata_o(of_rd));
  gasp_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_oh (
    .clk_i, .we_i(oh_we), .waddr_i(oh_wa), .wdata_i(oh_wd),
    .raddr_i(oh_ra), .rdata_o(oh_rd));
  gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELLS + 1)) u_path (
    .clk_i, .we_i(path_we), .waddr_i(path_wa), .wdata_i(path_wd),
    .raddr_i(path_ra), .rdata_o(path_rd));

  // The open list never holds more items than there are cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IDX_W'(CELLS))
    else $error("open list count exceeds the cell count");

  // No request is taken while the map or the list marks are being swept.
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL || state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("request taken during a memory sweep");

  // A found path always has at least one step.
  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STAT_FOUND) |-> (m_axis_tdata[12:0] != '0))
    else $error("path found with zero length");

  // Heap slot zero is never used.
  a_heap_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_we |-> (heap_wa != '0))
    else $error("write to heap slot zero");

endmodule
